[rtl/hlcc_pkg.sv]
package hlcc_pkg;
  localparam int unsigned TableSlotsDef = 256;
  localparam logic [63:0] Golden = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MulA   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MulB   = 64'h94d049bb133111eb;
  localparam int unsigned LaneLimit = 64;

  typedef struct packed {
    logic        action;
    logic [63:0] converge_id;
    logic [63:0] shape_id;
    logic [63:0] eligible_lanes;
    logic [7:0]  lane;
  } req_t;

  typedef struct packed {
    logic [7:0]  chosen_lane;
    logic        status;
    logic        was_hit;
    logic [63:0] probe_total;
    logic [63:0] hit_total;
  } rsp_t;
endpackage

[rtl/hlcc_req_if.sv]
interface hlcc_req_if;
  logic            valid;
  logic            ready;
  hlcc_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/hlcc_rsp_if.sv]
interface hlcc_rsp_if;
  logic            valid;
  logic            ready;
  hlcc_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/hashed_lane_choice_cache_core.sv]
// Steps: after the accept, S_PRE, then S_XS and S_MUL for each of the two multiplies, then
// S_KEY; S_RD, S_WAIT and S_CHK per probed slot; on a select miss S_LOW scans for the lowest
// eligible lane; then S_OUT. An empty-mask select or a rejected commit goes straight to S_OUT.
// Items run one at a time: the next item is taken in the cycle after the result leaves.
// The hash uses one shared 32x32 multiplier over 3 partial products per 64-bit multiply.
// Reset (async, low): counters, fingerprint and control clear at once, then a clearing
// pass empties every slot of the valid-free key memory before any item is taken.
module hashed_lane_choice_cache_core #(
  parameter int unsigned TABLE_SLOTS = hlcc_pkg::TableSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  hlcc_req_if.sink    req_i,
  hlcc_rsp_if.source  rsp_o
);
  localparam int unsigned IW = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IW-1:0] IMask = IW'(TABLE_SLOTS - 1);
  localparam logic [IW:0] Cnt = (IW+1)'(TABLE_SLOTS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PRE, S_MUL, S_XS, S_KEY, S_RD, S_WAIT, S_CHK, S_LOW, S_OUT
  } state_e;

  state_e      state_q;
  logic [IW:0] clr_q;
  logic [63:0] fp_q, probes_q, hits_q;
  hlcc_pkg::req_t req_q;
  logic [63:0] v_q, acc_q;
  logic [1:0]  pp_q;
  logic        mul_sel_q;        // 0: MulA, 1: MulB
  logic [63:0] key_q;
  logic [IW-1:0] idx_q, stride_q, base_q;
  logic [IW:0] att_q;
  logic [5:0]  low_q;
  logic [63:0] rd_key_q;
  logic [5:0]  rd_lane_q;
  logic [7:0]  chosen_q;
  logic        status_q, hit_q;

  logic [63:0] mem_key [TABLE_SLOTS];
  logic [5:0]  mem_lane [TABLE_SLOTS];

  // shared multiplier: one 32x32 partial product per cycle
  logic [31:0] ma, mb;
  logic [63:0] pp, mc;
  assign mc = mul_sel_q ? hlcc_pkg::MulB : hlcc_pkg::MulA;
  always_comb begin
    unique case (pp_q)
      2'd0: begin ma = v_q[31:0];  mb = mc[31:0];  end
      2'd1: begin ma = v_q[63:32]; mb = mc[31:0];  end
      2'd2: begin ma = v_q[31:0];  mb = mc[63:32]; end
      default: begin ma = v_q[31:0]; mb = mc[31:0]; end
    endcase
    pp = 64'(ma) * 64'(mb);
  end

  // final xor-shift of the hash; the table key and probe indices come from it
  logic [63:0] key_mix;
  assign key_mix = (v_q ^ (v_q >> 31)) | 64'd1;

  logic        mem_we;
  logic [IW-1:0] mem_wa;
  logic [63:0] mem_wk;
  logic [5:0]  mem_wl;
  logic        lane_ok;
  assign lane_ok = req_q.eligible_lanes[rd_lane_q];
  logic match;
  assign match = (rd_key_q == key_q);
  logic empty;
  assign empty = (rd_key_q == 64'd0);
  logic commit_hit;
  assign commit_hit = (state_q == S_CHK) && req_q.action && (empty || match);
  logic commit_full;
  assign commit_full = (state_q == S_CHK) && req_q.action && !(empty || match) &&
                       (att_q == Cnt - 1'b1);

  always_comb begin
    mem_we = 1'b0; mem_wa = idx_q; mem_wk = key_q; mem_wl = req_q.lane[5:0];
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1; mem_wa = clr_q[IW-1:0]; mem_wk = '0; mem_wl = '0;
    end else if (commit_hit) begin
      mem_we = 1'b1;
    end else if (commit_full) begin
      mem_we = 1'b1; mem_wa = base_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_key[mem_wa]  <= mem_wk;
      mem_lane[mem_wa] <= mem_wl;
    end
    rd_key_q  <= mem_key[idx_q];
    rd_lane_q <= mem_lane[idx_q];
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = (state_q == S_OUT);
  assign rsp_o.data  = '{chosen_lane: chosen_q, status: status_q, was_hit: hit_q,
                         probe_total: probes_q, hit_total: hits_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; fp_q <= '0; probes_q <= '0; hits_q <= '0;
      pp_q <= '0; mul_sel_q <= 1'b0; att_q <= '0; low_q <= '0;
    end else begin
      if (cfg_we_i) fp_q <= cfg_wdata_i;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == Cnt - 1'b1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req_i.valid) begin
            req_q <= req_i.data;
            chosen_q <= req_i.data.lane; status_q <= 1'b0; hit_q <= 1'b0;
            low_q <= '0;
            if (!req_i.data.action && req_i.data.eligible_lanes == '0) begin
              state_q <= S_OUT;
            end else if (req_i.data.action && (req_i.data.lane >= 8'(hlcc_pkg::LaneLimit) ||
                         !req_i.data.eligible_lanes[req_i.data.lane[5:0]])) begin
              status_q <= 1'b1; state_q <= S_OUT;
            end else begin
              state_q <= S_PRE;
            end
          end
        end
        S_PRE: begin
          v_q <= (req_q.converge_id ^ (req_q.shape_id + hlcc_pkg::Golden) ^ fp_q)
                 + hlcc_pkg::Golden;
          mul_sel_q <= 1'b0;
          state_q <= S_XS;
        end
        S_XS: begin
          // xor-shift before each multiply: 30 before MulA, 27 before MulB
          v_q <= mul_sel_q ? (v_q ^ (v_q >> 27)) : (v_q ^ (v_q >> 30));
          acc_q <= '0; pp_q <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          unique case (pp_q)
            2'd0: acc_q <= pp;
            default: acc_q <= acc_q + {pp[31:0], 32'd0};
          endcase
          if (pp_q == 2'd2) begin
            v_q <= acc_q + {pp[31:0], 32'd0};
            if (mul_sel_q) state_q <= S_KEY;
            else begin mul_sel_q <= 1'b1; state_q <= S_XS; end
          end
          pp_q <= pp_q + 2'd1;
        end
        S_KEY: begin
          key_q    <= key_mix;
          base_q   <= key_mix[IW-1:0] & IMask;
          idx_q    <= key_mix[IW-1:0] & IMask;
          stride_q <= IW'((key_mix >> 6) | 64'd1) & IMask;
          att_q    <= '0;
          state_q  <= S_RD;
        end
        S_RD: state_q <= S_WAIT;
        S_WAIT: state_q <= S_CHK;
        S_CHK: begin
          if (req_q.action) begin
            if (empty || match || att_q == Cnt - 1'b1) state_q <= S_OUT;
            else begin
              att_q <= att_q + 1'b1; idx_q <= (idx_q + stride_q) & IMask; state_q <= S_RD;
            end
          end else begin
            probes_q <= probes_q + 64'd1;
            if (match && lane_ok) begin
              hits_q <= hits_q + 64'd1; chosen_q <= {2'b00, rd_lane_q}; hit_q <= 1'b1;
              state_q <= S_OUT;
            end else if (empty || att_q == Cnt - 1'b1) begin
              state_q <= S_LOW;
            end else begin
              att_q <= att_q + 1'b1; idx_q <= (idx_q + stride_q) & IMask; state_q <= S_RD;
            end
          end
        end
        S_LOW: begin
          // one bit per cycle; bit 63 is taken if nothing lower is set
          if (req_q.eligible_lanes[low_q] || low_q == 6'd63) begin
            chosen_q <= {2'b00, low_q}; state_q <= S_OUT;
          end else low_q <= low_q + 6'd1;
        end
        S_OUT: if (rsp_o.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
